// ----- hw/rtl/idpa_pkg.sv -----
// Shared types, constants and helper functions for the ID pool allocator.
// No dependencies; used by idpa_bitmap and id_pool_allocator_core.
package idpa_pkg;

   localparam int POOL_SIZE      = 256;
   localparam int ID_WIDTH       = 8;
   localparam int COUNT_WIDTH    = 9;
   localparam int ROW_WIDTH      = 32;
   localparam int ROW_COUNT      = POOL_SIZE / ROW_WIDTH;
   localparam int ROW_IDX_WIDTH  = $clog2(ROW_COUNT);
   localparam int BIT_IDX_WIDTH  = $clog2(ROW_WIDTH);
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [COUNT_WIDTH-1:0] POOL_COUNT = COUNT_WIDTH'(POOL_SIZE);
   localparam logic [COUNT_WIDTH-1:0] INIT_COUNT_RESET = COUNT_WIDTH'(1);

   // Operation codes
   localparam logic [2:0] OP_ALLOC   = 3'd0;
   localparam logic [2:0] OP_CLAIM   = 3'd1;
   localparam logic [2:0] OP_RELEASE = 3'd2;
   localparam logic [2:0] OP_QUERY   = 3'd3;
   localparam logic [2:0] OP_GROW    = 3'd4;

   // Register index of initial_id_count
   localparam logic CSR_IDX_INIT_COUNT = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_CHECK
   } state_type;

   typedef struct packed {
      logic [2:0]             op;
      logic [ID_WIDTH-1:0]    id;
      logic [COUNT_WIDTH-1:0] amount;
   } req_type;

   typedef struct packed {
      logic                   ok;
      logic [ID_WIDTH-1:0]    result_id;
      logic [COUNT_WIDTH-1:0] limit_now;
      logic [COUNT_WIDTH-1:0] free_now;
   } rsp_type;

   // Bitmap access request from the sequencer
   typedef struct packed {
      logic                     rd_en;
      logic [ROW_IDX_WIDTH-1:0] rd_row;
      logic                     wr_en;
      logic [ROW_IDX_WIDTH-1:0] wr_row;
      logic [ROW_WIDTH-1:0]     wr_data;
   } bm_req_type;

   // Zero maps to one, anything above the pool size saturates.
   function automatic logic [COUNT_WIDTH-1:0] effective_count(
      input logic [COUNT_WIDTH-1:0] n);
      logic [COUNT_WIDTH-1:0] r;
      r = n;
      if (n == '0) begin
         r = COUNT_WIDTH'(1);
      end else if (n > POOL_COUNT) begin
         r = POOL_COUNT;
      end
      return r;
   endfunction

   // Amount actually added to the limit, capped by the room left.
   function automatic logic [COUNT_WIDTH-1:0] capped_add(
      input logic [COUNT_WIDTH-1:0] limit,
      input logic [COUNT_WIDTH-1:0] add);
      logic [COUNT_WIDTH-1:0] room;
      room = POOL_COUNT - limit;
      return (add > room) ? room : add;
   endfunction

   // Position of the lowest clear bit in a row (row must not be all ones).
   function automatic logic [BIT_IDX_WIDTH-1:0] lowest_zero(
      input logic [ROW_WIDTH-1:0] row);
      logic [BIT_IDX_WIDTH-1:0] pos;
      pos = '0;
      for (int i = ROW_WIDTH - 1; i >= 0; i--) begin
         if (!row[i]) begin
            pos = BIT_IDX_WIDTH'(i);
         end
      end
      return pos;
   endfunction

endpackage

// ----- hw/rtl/idpa_bitmap.sv -----
// Taken-ID bitmap: a row-organized synchronous memory with registered read
// data and per-row valid bits. Depends on idpa_pkg.
module idpa_bitmap (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             clear,
   input  idpa_pkg::bm_req_type             req,
   output logic [idpa_pkg::ROW_WIDTH-1:0]   rd_data
);

   logic [idpa_pkg::ROW_WIDTH-1:0] mem [idpa_pkg::ROW_COUNT];
   logic [idpa_pkg::ROW_COUNT-1:0] row_valid_ff;
   logic [idpa_pkg::ROW_WIDTH-1:0] rd_data_ff;
   logic                           rd_valid_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_row] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.rd_row];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (req.wr_en) begin
            row_valid_ff[req.wr_row] <= 1'b1;
         end
         if (req.rd_en) begin
            rd_valid_ff <= row_valid_ff[req.rd_row];
         end
      end
   end

   // A row never written reads as all free
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ----- hw/rtl/id_pool_allocator_core.sv -----
// ID pool allocator top level: request sequencer, limit and free counters,
// APB-style register port. Depends on idpa_pkg and idpa_bitmap.
//
// Usage: assert start with a request on req_data while busy is low; the
// request is taken at that edge and busy rises. Exactly one response
// follows per request, on rsp_data for a single cycle marked by rsp_strobe;
// the receiver cannot stall it, so sample it when the strobe is high.
// Grow, unused op codes and an allocate that still finds no free ID after
// doubling the limit finish in PREP; claim, release and query go through
// PREP and CHECK; a successful allocate-lowest stays in CHECK while it
// reads each further 32-bit bitmap row past row 0 in search of a clear
// bit, since the bitmap memory returns one row per cycle. The response
// strobe is high in the first cycle in which busy is low again, and a new
// start may be given in that same cycle. Writing initial_id_count
// (address 0) restarts the pool at once: all IDs free, limit and free
// count load the initial count from bits 8:0 (zero counts as one, values
// above 256 saturate). Write it only while the block is idle.
module id_pool_allocator_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  start,
   output logic                                  busy,
   input  idpa_pkg::req_type                     req_data,
   // response channel
   output logic                                  rsp_strobe,
   output idpa_pkg::rsp_type                     rsp_data,
   // register port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [idpa_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [idpa_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [idpa_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                  pready
);

   localparam int CW = idpa_pkg::COUNT_WIDTH;

   idpa_pkg::state_type                  state_ff, state_in;
   idpa_pkg::req_type                    req_ff;
   logic [idpa_pkg::ROW_IDX_WIDTH-1:0]   row_ff, row_in;
   logic [CW-1:0]                        limit_ff, limit_in;
   logic [CW-1:0]                        free_ff, free_in;
   logic [CW-1:0]                        init_ff;
   logic                                 rsp_strobe_ff;
   idpa_pkg::rsp_type                    rsp_data_ff;

   logic                                 accept;
   logic                                 cfg_write;
   logic                                 fire;
   logic                                 rsp_ok;
   logic [idpa_pkg::ID_WIDTH-1:0]        rsp_rid;
   logic [CW-1:0]                        add;
   logic                                 in_range;
   logic                                 id_bit;
   logic [idpa_pkg::BIT_IDX_WIDTH-1:0]   id_pos;
   logic [idpa_pkg::ROW_IDX_WIDTH-1:0]   id_row;
   logic [idpa_pkg::BIT_IDX_WIDTH-1:0]   free_pos;
   logic [idpa_pkg::ROW_WIDTH-1:0]       row_data;
   idpa_pkg::bm_req_type                 bm_req;

   assign accept    = start && !busy;
   assign cfg_write = psel && penable && pwrite && pready &&
                      (paddr[2] == idpa_pkg::CSR_IDX_INIT_COUNT);

   // Register port: single register, always ready
   assign pready = 1'b1;
   assign prdata = (paddr[2] == idpa_pkg::CSR_IDX_INIT_COUNT)
                   ? idpa_pkg::CSR_DATA_WIDTH'(init_ff) : '0;

   assign busy = (state_ff != idpa_pkg::ST_IDLE);

   // Split the requested ID into bitmap row and bit position
   assign id_row = req_ff.id[idpa_pkg::ID_WIDTH-1 -: idpa_pkg::ROW_IDX_WIDTH];
   assign id_pos = req_ff.id[idpa_pkg::BIT_IDX_WIDTH-1:0];

   assign in_range = ({1'b0, req_ff.id} < limit_ff);
   assign id_bit   = row_data[id_pos];
   assign free_pos = idpa_pkg::lowest_zero(row_data);

   idpa_bitmap u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .clear   (cfg_write),
      .req     (bm_req),
      .rd_data (row_data)
   );

   // Sequencer: PREP applies limit changes, then reads the first row or ends
   // the request; CHECK inspects the row, writes it back and ends or reads on.
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      limit_in = limit_ff;
      free_in  = free_ff;
      fire     = 1'b0;
      rsp_ok   = 1'b0;
      rsp_rid  = '0;
      add      = '0;
      bm_req   = '0;

      unique case (state_ff)
         idpa_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = idpa_pkg::ST_PREP;
            end
         end

         idpa_pkg::ST_PREP: begin
            unique case (req_ff.op) inside
               idpa_pkg::OP_ALLOC, idpa_pkg::OP_CLAIM: begin
                  // Double the limit when nothing is free
                  if (free_ff == '0) begin
                     add = idpa_pkg::capped_add(limit_ff, limit_ff);
                  end
                  limit_in = limit_ff + add;
                  free_in  = free_ff + add;
                  if (req_ff.op == idpa_pkg::OP_ALLOC) begin
                     if (free_in == '0) begin
                        fire     = 1'b1;
                        state_in = idpa_pkg::ST_IDLE;
                     end else begin
                        row_in        = '0;
                        bm_req.rd_en  = 1'b1;
                        bm_req.rd_row = '0;
                        state_in      = idpa_pkg::ST_CHECK;
                     end
                  end else begin
                     bm_req.rd_en  = 1'b1;
                     bm_req.rd_row = id_row;
                     state_in      = idpa_pkg::ST_CHECK;
                  end
               end
               idpa_pkg::OP_RELEASE, idpa_pkg::OP_QUERY: begin
                  bm_req.rd_en  = 1'b1;
                  bm_req.rd_row = id_row;
                  state_in      = idpa_pkg::ST_CHECK;
               end
               idpa_pkg::OP_GROW: begin
                  add      = idpa_pkg::capped_add(limit_ff, req_ff.amount);
                  limit_in = limit_ff + add;
                  free_in  = free_ff + add;
                  rsp_ok   = (req_ff.amount != '0) && (add != '0);
                  fire     = 1'b1;
                  state_in = idpa_pkg::ST_IDLE;
               end
               default: begin
                  // Unused codes: fail, no change
                  fire     = 1'b1;
                  state_in = idpa_pkg::ST_IDLE;
               end
            endcase
         end

         idpa_pkg::ST_CHECK: begin
            unique case (req_ff.op)
               idpa_pkg::OP_ALLOC: begin
                  // A free ID is known to exist below the limit, and all IDs
                  // at or above it are clear, so the first clear bit wins.
                  if (row_data != '1) begin
                     bm_req.wr_en   = 1'b1;
                     bm_req.wr_row  = row_ff;
                     bm_req.wr_data = row_data |
                        (idpa_pkg::ROW_WIDTH'(1) << free_pos);
                     free_in  = free_ff - CW'(1);
                     rsp_ok   = 1'b1;
                     rsp_rid  = {row_ff, free_pos};
                     fire     = 1'b1;
                     state_in = idpa_pkg::ST_IDLE;
                  end else begin
                     // Advance to the next row
                     row_in        = row_ff + idpa_pkg::ROW_IDX_WIDTH'(1);
                     bm_req.rd_en  = 1'b1;
                     bm_req.rd_row = row_in;
                  end
               end
               idpa_pkg::OP_CLAIM: begin
                  if (in_range && !id_bit) begin
                     bm_req.wr_en   = 1'b1;
                     bm_req.wr_row  = id_row;
                     bm_req.wr_data = row_data |
                        (idpa_pkg::ROW_WIDTH'(1) << id_pos);
                     free_in = free_ff - CW'(1);
                     rsp_ok  = 1'b1;
                  end
                  fire     = 1'b1;
                  state_in = idpa_pkg::ST_IDLE;
               end
               idpa_pkg::OP_RELEASE: begin
                  if (in_range && id_bit) begin
                     bm_req.wr_en   = 1'b1;
                     bm_req.wr_row  = id_row;
                     bm_req.wr_data = row_data &
                        ~(idpa_pkg::ROW_WIDTH'(1) << id_pos);
                     free_in = free_ff + CW'(1);
                     rsp_ok  = 1'b1;
                  end
                  fire     = 1'b1;
                  state_in = idpa_pkg::ST_IDLE;
               end
               idpa_pkg::OP_QUERY: begin
                  rsp_ok   = in_range && !id_bit;
                  fire     = 1'b1;
                  state_in = idpa_pkg::ST_IDLE;
               end
               default: begin
                  fire     = 1'b1;
                  state_in = idpa_pkg::ST_IDLE;
               end
            endcase
         end

         default: begin
            state_in = idpa_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state; a register write restarts the pool
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= idpa_pkg::ST_IDLE;
         init_ff       <= idpa_pkg::INIT_COUNT_RESET;
         limit_ff      <= idpa_pkg::INIT_COUNT_RESET;
         free_ff       <= idpa_pkg::INIT_COUNT_RESET;
         row_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else if (cfg_write) begin
         state_ff      <= idpa_pkg::ST_IDLE;
         init_ff       <= pwdata[CW-1:0];
         limit_ff      <= idpa_pkg::effective_count(pwdata[CW-1:0]);
         free_ff       <= idpa_pkg::effective_count(pwdata[CW-1:0]);
         row_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         limit_ff      <= limit_in;
         free_ff       <= free_in;
         row_ff        <= row_in;
         rsp_strobe_ff <= fire;
      end
   end

   // Payload registers: hold the request, capture the response
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff.ok        <= rsp_ok;
         rsp_data_ff.result_id <= rsp_rid;
         rsp_data_ff.limit_now <= limit_in;
         rsp_data_ff.free_now  <= free_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ----- tb/idpa_pool_checker.sv -----
// Response checker for the ID pool allocator: keeps its own bitmap pool model,
// predicts one response per accepted request and compares field by field.
// Depends on idpa_pkg; instantiated next to the block by the test top.
module idpa_pool_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  idpa_pkg::req_type                   req_data,
   input  logic                                rsp_strobe,
   input  idpa_pkg::rsp_type                   rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [idpa_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [idpa_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   input  logic [idpa_pkg::CSR_DATA_WIDTH-1:0] prdata,
   input  logic                                pready,
   output int                                  response_backlog,
   output int                                  mismatch_count
);

   localparam int AW = idpa_pkg::CSR_ADDR_WIDTH;
   localparam int DW = idpa_pkg::CSR_DATA_WIDTH;
   localparam int CW = idpa_pkg::COUNT_WIDTH;
   localparam int POOL = idpa_pkg::POOL_SIZE;
   localparam logic [AW-1:0] INIT_COUNT_ADDR =
      AW'(4 * idpa_pkg::CSR_IDX_INIT_COUNT);

   logic                taken [POOL];
   int                  pool_limit;
   int                  pool_free;
   logic [8:0]          init_count_reg;
   idpa_pkg::rsp_type   owed_responses [$];
   idpa_pkg::rsp_type   owed;

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   task automatic restart_pool();
      for (int i = 0; i < POOL; i++) begin
         taken[i] = 1'b0;
      end
      pool_limit = (init_count_reg == 9'd0) ? 1 :
                   (int'(init_count_reg) > POOL) ? POOL : int'(init_count_reg);
      pool_free  = pool_limit;
   endtask

   // Raise the limit, saturating at the pool size; return the IDs added.
   function automatic int widen_limit(input int add);
      int room;
      room = POOL - pool_limit;
      if (add > room) begin
         add = room;
      end
      pool_limit += add;
      pool_free  += add;
      return add;
   endfunction

   task automatic apply_pool_op(input idpa_pkg::req_type r, output idpa_pkg::rsp_type p);
      logic       ok;
      logic [7:0] handed;
      int         slot;
      ok     = 1'b0;
      handed = '0;
      slot   = int'(r.id);
      case (r.op)
         idpa_pkg::OP_ALLOC: begin
            if (pool_free == 0) begin
               void'(widen_limit(pool_limit));
            end
            if (pool_free != 0) begin
               for (int i = 0; i < pool_limit && !ok; i++) begin
                  if (!taken[i]) begin
                     taken[i] = 1'b1;
                     pool_free--;
                     handed = 8'(i);
                     ok = 1'b1;
                  end
               end
            end
         end
         idpa_pkg::OP_CLAIM: begin
            if (pool_free == 0) begin
               void'(widen_limit(pool_limit));
            end
            if (slot < pool_limit && !taken[slot]) begin
               taken[slot] = 1'b1;
               pool_free--;
               ok = 1'b1;
            end
         end
         idpa_pkg::OP_RELEASE: begin
            if (slot < pool_limit && taken[slot]) begin
               taken[slot] = 1'b0;
               pool_free++;
               ok = 1'b1;
            end
         end
         idpa_pkg::OP_QUERY: begin
            ok = (slot < pool_limit && !taken[slot]);
         end
         idpa_pkg::OP_GROW: begin
            if (r.amount != '0 && widen_limit(int'(r.amount)) != 0) begin
               ok = 1'b1;
            end
         end
         default: begin
         end
      endcase
      p.ok        = ok;
      p.result_id = handed;
      p.limit_now = CW'(pool_limit);
      p.free_now  = CW'(pool_free);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mismatch_count = 0;
         init_count_reg = idpa_pkg::INIT_COUNT_RESET;
         restart_pool();
         owed_responses.delete();
         response_backlog <= 0;
      end else begin
         // Compare first: a new request may be taken at the edge that ends a response.
         if (rsp_strobe) begin
            if (owed_responses.size() == 0) begin
               flag_mismatch("unexpected response, free_now", rsp_data.free_now, 0);
            end else begin
               owed = owed_responses[0];
               owed_responses.delete(0);
               if (rsp_data.ok !== owed.ok)
                  flag_mismatch("ok", rsp_data.ok, owed.ok);
               if (rsp_data.result_id !== owed.result_id)
                  flag_mismatch("result_id", rsp_data.result_id, owed.result_id);
               if (rsp_data.limit_now !== owed.limit_now)
                  flag_mismatch("limit_now", rsp_data.limit_now, owed.limit_now);
               if (rsp_data.free_now !== owed.free_now)
                  flag_mismatch("free_now", rsp_data.free_now, owed.free_now);
            end
         end
         if (psel && penable && pready && paddr == INIT_COUNT_ADDR) begin
            if (pwrite) begin
               init_count_reg = pwdata[CW-1:0];
               restart_pool();
            end else if (prdata !== DW'(init_count_reg)) begin
               flag_mismatch("initial_id_count readback", prdata, init_count_reg);
            end
         end
         if (start && !busy) begin
            apply_pool_op(req_data, owed);
            owed_responses.insert(owed_responses.size(), owed);
         end
         response_backlog <= owed_responses.size();
      end
   end

endmodule

// ----- tb/id_pool_allocator_core_test.sv -----
// Test top for id_pool_allocator_core: clock, reset, request and register
// stimulus, and the verdict. Depends on idpa_pkg, the core and idpa_pool_checker.
module id_pool_allocator_core_test;

   localparam int AW = idpa_pkg::CSR_ADDR_WIDTH;
   localparam int DW = idpa_pkg::CSR_DATA_WIDTH;

   // Op codes the block leaves unused; they must answer with ok low.
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_MID   = 3'd6;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

   localparam logic [AW-1:0] INIT_COUNT_ADDR =
      AW'(4 * idpa_pkg::CSR_IDX_INIT_COUNT);

   localparam int CLOCK_HIGH      = 4;
   localparam int CLOCK_LOW       = 4;
   localparam int RESET_CYCLES    = 7;
   localparam int PHASES          = 6;
   localparam int REQS_PER_PHASE  = 300;
   localparam int TAIL_CYCLES     = 12;
   localparam int TIMEOUT_CYCLES  = 500000;

   logic                      clock    = 1'b0;
   logic                      reset    = 1'b1;
   logic                      start    = 1'b0;
   idpa_pkg::req_type         req_data = '0;
   logic                      psel     = 1'b0;
   logic                      penable  = 1'b0;
   logic                      pwrite   = 1'b0;
   logic [AW-1:0]             paddr    = '0;
   logic [DW-1:0]             pwdata   = '0;

   logic                      busy;
   logic                      rsp_strobe;
   idpa_pkg::rsp_type         rsp_data;
   logic [DW-1:0]             prdata;
   logic                      pready;
   int                        response_backlog;
   int                        mismatch_count;

   // Chance in percent that the sender rests in any one cycle.
   int idle_pct;

   // Per phase: initial count to load, and how allocate-heavy the mix is.
   // The heavy phases drive the pool to full so allocate runs out.
   logic [8:0] phase_count  [PHASES] = '{9'd0, 9'd256, 9'd3, 9'd511, 9'd100, 9'd1};
   int         phase_alloc  [PHASES] = '{40, 95, 40, 95, 50, 40};

   always begin
      #CLOCK_LOW  clock = 1'b1;
      #CLOCK_HIGH clock = 1'b0;
   end

   id_pool_allocator_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   idpa_pool_checker pool_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data         (req_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_data         (rsp_data),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .response_backlog (response_backlog),
      .mismatch_count   (mismatch_count)
   );

   function automatic idpa_pkg::req_type make_request(input logic [2:0] op,
                                                      input logic [7:0] id,
                                                      input logic [8:0] amount);
      idpa_pkg::req_type r;
      r.op     = op;
      r.id     = id;
      r.amount = amount;
      return r;
   endfunction

   // Rest for a random number of cycles, then present a request and hold
   // start until the block takes it. The caller is always just past an edge.
   task automatic issue(input idpa_pkg::req_type r);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   // Drop start and hold off until every owed response has come back.
   // The backlog is registered at the edge, so step past an edge first.
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (response_backlog != 0) @(posedge clock);
   endtask

   // One register access: setup cycle, access cycle, then a quiet cycle
   // so that back-to-back accesses never touch psel twice in a step.
   task automatic csr_access(input logic wr, input logic [8:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= INIT_COUNT_ADDR;
      pwdata  <= DW'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_request(input int alloc_pct, output idpa_pkg::req_type r);
      logic [7:0] id_mask;
      int         pick;
      int         amount_kind;
      case ($urandom_range(0, 2))
         0:       id_mask = 8'h07;
         1:       id_mask = 8'h3F;
         default: id_mask = 8'hFF;
      endcase
      r.id = 8'($urandom_range(0, 255)) & id_mask;
      // Mostly small growth; some zero, some past the pool size.
      amount_kind = $urandom_range(0, 9);
      case (amount_kind)
         0:       r.amount = '0;
         1:       r.amount = 9'($urandom_range(257, 511));
         2:       r.amount = 9'($urandom_range(0, 511));
         default: r.amount = 9'($urandom_range(1, 16));
      endcase
      if ($urandom_range(0, 99) < alloc_pct) begin
         r.op = idpa_pkg::OP_ALLOC;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 25)      r.op = idpa_pkg::OP_CLAIM;
         else if (pick < 65) r.op = idpa_pkg::OP_RELEASE;
         else if (pick < 85) r.op = idpa_pkg::OP_QUERY;
         else if (pick < 97) r.op = idpa_pkg::OP_GROW;
         else                r.op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      end
   endtask

   // Hard stop in case the block hangs or drops a response.
   initial begin
      #((CLOCK_HIGH + CLOCK_LOW) * TIMEOUT_CYCLES);
      $display("FAIL");
      $finish;
   end

   initial begin
      idpa_pkg::req_type r;
      idle_pct = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, on the reset count of one ID.
      issue(make_request(idpa_pkg::OP_QUERY,   8'd0,   9'd0));    // the only ID is free
      issue(make_request(idpa_pkg::OP_ALLOC,   8'd0,   9'd0));    // takes ID 0, pool full
      issue(make_request(idpa_pkg::OP_ALLOC,   8'd0,   9'd0));    // exhausted: limit doubles
      issue(make_request(idpa_pkg::OP_CLAIM,   8'd0,   9'd0));    // doubles, claim of taken
      issue(make_request(idpa_pkg::OP_CLAIM,   8'd3,   9'd0));    // named ID within the limit
      issue(make_request(idpa_pkg::OP_CLAIM,   8'd255, 9'd0));    // above the limit
      issue(make_request(idpa_pkg::OP_RELEASE, 8'd255, 9'd0));    // above the limit
      issue(make_request(idpa_pkg::OP_RELEASE, 8'd2,   9'd0));    // release of a free ID
      issue(make_request(idpa_pkg::OP_RELEASE, 8'd0,   9'd0));
      issue(make_request(idpa_pkg::OP_QUERY,   8'd255, 9'd0));    // query above the limit
      issue(make_request(idpa_pkg::OP_QUERY,   8'd0,   9'd0));
      issue(make_request(idpa_pkg::OP_GROW,    8'd0,   9'd0));    // grow by zero
      issue(make_request(idpa_pkg::OP_GROW,    8'd0,   9'd1));
      issue(make_request(idpa_pkg::OP_GROW,    8'd0,   9'd511));  // past the pool size
      issue(make_request(idpa_pkg::OP_GROW,    8'd0,   9'd1));    // already at the pool size
      issue(make_request(OP_SPARE_FIRST, 8'd255, 9'd511));
      issue(make_request(OP_SPARE_MID,   8'd0,   9'd0));
      issue(make_request(OP_SPARE_LAST,  8'd170, 9'd341));
      issue(make_request(idpa_pkg::OP_CLAIM,   8'd255, 9'd0));    // top ID, now in the limit
      issue(make_request(idpa_pkg::OP_RELEASE, 8'd255, 9'd0));
      issue(make_request(idpa_pkg::OP_QUERY,   8'hAA,  9'h155));
      issue(make_request(idpa_pkg::OP_ALLOC,   8'h55,  9'h0AA));  // other fields ignored
      issue(make_request(idpa_pkg::OP_ALLOC,   8'd0,   9'd0));
      settle();

      // Random phases: reload the pool between them while the block is idle.
      for (int phase = 0; phase < PHASES; phase++) begin
         idle_pct = (phase < 2) ? 29 : (phase < 4) ? 62 : 0;
         csr_access(1'b1, phase_count[phase]);
         csr_access(1'b0, '0);
         for (int k = 0; k < REQS_PER_PHASE; k++) begin
            random_request(phase_alloc[phase], r);
            issue(r);
            // Now and then let the pipeline run dry before the next request.
            if ($urandom_range(0, 63) == 0) begin
               settle();
            end
         end
         settle();
      end

      // Allow for any stray response, then read the verdict off the edge.
      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
